// ----- hdl/glos_pkg.sv -----
// shared types and constants of the grid line-of-sight block
package glos_pkg;

  // coordinate fields are fixed at 6 bits
  localparam int unsigned CW = 6;
  typedef logic [CW-1:0] coord_t;

  // crossing terms (2i+1)*dy and (2j+1)*dx stay below 2^14 for 6-bit coordinates
  localparam int unsigned EW = 14;
  typedef logic [EW-1:0] cross_t;

  // twice a coordinate distance
  typedef logic [CW:0] dist2_t;

  // walk sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP,
    ST_READ,
    ST_TIE_A,
    ST_TIE_B,
    ST_DONE
  } state_t;

endpackage

// ----- hdl/glos_if.sv -----
// request and result channel interfaces of the grid line-of-sight block
interface glos_in_if;
  logic                valid;
  logic                ready;
  logic                mode;
  glos_pkg::coord_t    src_x;
  glos_pkg::coord_t    src_y;
  glos_pkg::coord_t    dst_x;
  glos_pkg::coord_t    dst_y;
  logic                blocked_value;

  modport source (output valid, mode, src_x, src_y, dst_x, dst_y, blocked_value,
                  input ready);
  modport sink   (input valid, mode, src_x, src_y, dst_x, dst_y, blocked_value,
                  output ready);
endinterface

interface glos_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

// ----- hdl/grid_line_of_sight.sv -----
// grid line-of-sight top level: blocked-cell map and cell-by-cell walk sequencer
// a map write is taken while idle; writes are accepted back to back while idle
// a query result is registered once the walk reaches the destination or reads a blocked cell
// (one read per cell stepped into, two side reads per exact corner tie; coinciding endpoints read none)
// the next request is taken once the result is registered; a stalled result keeps the block busy
// reset is synchronous, active low; a clearing pass then holds ready low while it zeroes every map cell
module grid_line_of_sight #(
  parameter int unsigned GRID_DIM = 64
) (
  input  logic clk,
  input  logic rst_n,
  glos_in_if.sink    in_chan,
  glos_out_if.source out_chan
);
  import glos_pkg::*;

  localparam int unsigned DEPTH = GRID_DIM * GRID_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);

  // map address of a cell, row major
  function automatic logic [AW-1:0] cell_addr(coord_t x, coord_t y);
    return AW'(32'(y) * GRID_DIM + 32'(x));
  endfunction

  // cell lies inside the map
  function automatic logic in_map(coord_t x, coord_t y);
    return (32'(x) < GRID_DIM) && (32'(y) < GRID_DIM);
  endfunction

  state_t          state_r, state_nxt, mv_state;
  coord_t          sx_r, sy_r, tx_r, ty_r;
  coord_t          sx_nxt, sy_nxt, tx_nxt, ty_nxt;
  coord_t          cx_r, cy_r, cx_nxt, cy_nxt;
  coord_t          rdx_r, rdy_r, rdx_nxt, rdy_nxt;
  coord_t          nx, ny, adx, ady;
  cross_t          ex_r, ey_r, ex_nxt, ey_nxt;
  dist2_t          dx2_r, dy2_r, dx2_nxt, dy2_nxt;
  logic            decx_r, decy_r, decx_nxt, decy_nxt;
  logic            res_r, res_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_vis_r, out_vis_nxt;
  logic            in_acc, is_query, out_free;
  logic            cell_blk, at_tgt, ex_lt, ey_lt;
  logic            ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]   ram_waddr, ram_raddr;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign is_query = in_chan.mode;
  assign out_free = !out_valid_r || out_chan.ready;

  // absolute distances of the incoming query
  assign adx = (in_chan.dst_x > in_chan.src_x) ? in_chan.dst_x - in_chan.src_x
                                               : in_chan.src_x - in_chan.dst_x;
  assign ady = (in_chan.dst_y > in_chan.src_y) ? in_chan.dst_y - in_chan.src_y
                                               : in_chan.src_y - in_chan.dst_y;

  // neighbor coordinates toward the destination
  assign nx = decx_r ? cx_r - coord_t'(1) : cx_r + coord_t'(1);
  assign ny = decy_r ? cy_r - coord_t'(1) : cy_r + coord_t'(1);

  // shared step unit: crossing compare, target test, check of the cell just read
  always_comb begin
    at_tgt   = (cx_r == tx_r) && (cy_r == ty_r);
    ex_lt    = ex_r < ey_r;
    ey_lt    = ey_r < ex_r;
    cell_blk = ram_rdata && in_map(rdx_r, rdy_r) &&
               !((rdx_r == sx_r) && (rdy_r == sy_r)) &&
               !((rdx_r == tx_r) && (rdy_r == ty_r));
    if (at_tgt) begin
      mv_state = ST_DONE;
    end else if (ex_lt || ey_lt) begin
      mv_state = ST_READ;
    end else begin
      mv_state = ST_TIE_A;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && is_query) begin
          if ((in_chan.src_x == in_chan.dst_x) && (in_chan.src_y == in_chan.dst_y)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_STEP;
          end
        end
      end
      ST_STEP:  state_nxt = mv_state;
      ST_READ:  state_nxt = cell_blk ? ST_DONE : mv_state;
      ST_TIE_A: state_nxt = cell_blk ? ST_DONE : ST_TIE_B;
      ST_TIE_B: state_nxt = cell_blk ? ST_DONE : ST_READ;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    dx2_nxt       = dx2_r;
    dy2_nxt       = dy2_r;
    decx_nxt      = decx_r;
    decy_nxt      = decy_r;
    rdx_nxt       = rdx_r;
    rdy_nxt       = rdy_r;
    res_nxt       = res_r;
    clr_nxt       = clr_r;
    out_vis_nxt   = out_vis_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    ram_we        = 1'b0;
    ram_waddr     = cell_addr(in_chan.src_x, in_chan.src_y);
    ram_wdata     = in_chan.blocked_value;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 1'b0;
        clr_nxt   = clr_r + AW'(1);
      end
      ST_IDLE: begin
        // map write
        if (in_acc && !is_query && in_map(in_chan.src_x, in_chan.src_y)) begin
          ram_we = 1'b1;
        end
        // query setup
        if (in_acc && is_query) begin
          sx_nxt   = in_chan.src_x;
          sy_nxt   = in_chan.src_y;
          tx_nxt   = in_chan.dst_x;
          ty_nxt   = in_chan.dst_y;
          cx_nxt   = in_chan.src_x;
          cy_nxt   = in_chan.src_y;
          decx_nxt = in_chan.dst_x < in_chan.src_x;
          decy_nxt = in_chan.dst_y < in_chan.src_y;
          dx2_nxt  = {adx, 1'b0};
          dy2_nxt  = {ady, 1'b0};
          ex_nxt   = cross_t'(ady);
          ey_nxt   = cross_t'(adx);
          res_nxt  = 1'b1;
        end
      end
      ST_STEP, ST_READ: begin
        if (state_r == ST_READ && cell_blk) begin
          res_nxt = 1'b0;
        end else if (at_tgt) begin
          res_nxt = 1'b1;
        end else if (ex_lt) begin
          // column step
          cx_nxt  = nx;
          ex_nxt  = ex_r + cross_t'(dy2_r);
          rdx_nxt = nx;
          rdy_nxt = cy_r;
        end else if (ey_lt) begin
          // row step
          cy_nxt  = ny;
          ey_nxt  = ey_r + cross_t'(dx2_r);
          rdx_nxt = cx_r;
          rdy_nxt = ny;
        end else begin
          // corner tie: column neighbor first
          rdx_nxt = nx;
          rdy_nxt = cy_r;
        end
      end
      ST_TIE_A: begin
        if (cell_blk) begin
          res_nxt = 1'b0;
        end else begin
          rdx_nxt = cx_r;
          rdy_nxt = ny;
        end
      end
      ST_TIE_B: begin
        if (cell_blk) begin
          res_nxt = 1'b0;
        end else begin
          // diagonal move
          cx_nxt  = nx;
          cy_nxt  = ny;
          ex_nxt  = ex_r + cross_t'(dy2_r);
          ey_nxt  = ey_r + cross_t'(dx2_r);
          rdx_nxt = nx;
          rdy_nxt = ny;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vis_nxt   = res_r;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
    ram_raddr = cell_addr(rdx_nxt, rdy_nxt);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    tx_r      <= tx_nxt;
    ty_r      <= ty_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    dx2_r     <= dx2_nxt;
    dy2_r     <= dy2_nxt;
    decx_r    <= decx_nxt;
    decy_r    <= decy_nxt;
    rdx_r     <= rdx_nxt;
    rdy_r     <= rdy_nxt;
    res_r     <= res_nxt;
    out_vis_r <= out_vis_nxt;
  end

  // blocked-cell map
  glos_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // channel outputs
  assign in_chan.ready    = (state_r == ST_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.visible = out_vis_r;

endmodule

// ----- hdl/glos_ram.sv -----
// generic single-write, single-read RAM with registered read data
module glos_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/glos_check.sv -----
// port-level assertion checker for the grid line-of-sight block and its bind
module glos_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_mode,
  input logic out_valid,
  input logic out_ready,
  input logic out_visible
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_visible))
    else $error("stalled result changed");

  // the clearing pass keeps requests out right after reset
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("request taken during clearing pass");

  // an accepted query makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("ready high right after a query");

  // a map write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode |=> !$rose(out_valid))
    else $error("result appeared after a map write");

endmodule

bind grid_line_of_sight glos_check u_glos_check (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_mode     (in_chan.mode),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_visible (out_chan.visible)
);
